// ===== rtl/least_slack_time_scheduler_top_assert.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef LEAST_SLACK_TIME_SCHEDULER_TOP_ASSERT_SVH
`define LEAST_SLACK_TIME_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define LSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed: next-cycle rule");

// Rule on the cycle that follows a reset cycle.
`define LSTS_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("scheduler assertion failed: state after reset");

`endif

// ===== rtl/lsts_pkg.sv =====
`default_nettype none

package lsts_pkg;

    localparam int ID_W    = 8;
    localparam int POS_W   = 8;
    localparam int REM_W   = 16;
    localparam int TIME_W  = 31;
    localparam int SLACK_W = 33;
    localparam int SLICE_W = 32;

    typedef logic [ID_W-1:0]           t_id;
    typedef logic [POS_W-1:0]          t_pos;
    typedef logic [REM_W-1:0]          t_rem;
    typedef logic [TIME_W-1:0]         t_time;
    typedef logic signed [SLACK_W-1:0] t_slack;
    typedef logic signed [SLICE_W-1:0] t_slice;

    localparam logic ACT_RUN = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/least_slack_time_scheduler_top.sv =====
// o_out_valid rises once the last entry moves from the input register into the result register.
// Throughput: one entry per cycle, save that a last entry waits while a result is held; each
// entry passes an input register, then one compare-and-update of the running best registers
// and the result register. Reset (synchronous, active low) empties both registers and ends any open decision.
`default_nettype none

module least_slack_time_scheduler_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire                   i_action,
    input  lsts_pkg::t_id         i_thread_id,
    input  lsts_pkg::t_rem        i_remaining_time,
    input  lsts_pkg::t_time       i_due_time,
    input  lsts_pkg::t_time       i_release_at,
    input  lsts_pkg::t_time       i_now_time,
    input  wire                   i_last,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic                  o_idle,
    output lsts_pkg::t_id         o_winner_id,
    output lsts_pkg::t_pos        o_winner_position,
    output lsts_pkg::t_slice      o_slice_ticks
);
    import lsts_pkg::*;

    localparam logic [POS_W:0] MaxPos = (POS_W+1)'(MAX_ENTRIES);

    // Input register.
    logic   r_s1_valid;
    logic   r_s1_action;
    t_id    r_s1_id;
    t_rem   r_s1_rem;
    t_time  r_s1_due;
    t_time  r_s1_rel;
    t_time  r_s1_now;
    logic   r_s1_last;

    // Decision state.
    logic   r_in_decision, n_in_decision;
    logic   r_run_seen, n_run_seen;
    logic   r_release_seen, n_release_seen;
    t_pos   r_run_count, n_run_count;
    t_time  r_latched_now, n_latched_now;
    t_slack r_best_slack, n_best_slack;
    t_id    r_best_id, n_best_id;
    t_pos   r_best_position, n_best_position;
    t_time  r_best_due, n_best_due;
    t_slice r_slice_acc, n_slice_acc;
    t_time  r_earliest, n_earliest;
    t_id    r_earliest_id, n_earliest_id;

    // Result register.
    logic   r_out_valid;
    logic   r_out_idle, n_out_idle;
    t_id    r_out_id, n_out_id;
    t_pos   r_out_position, n_out_position;
    t_slice r_out_slice, n_out_slice;

    logic         out_free;
    logic         s1_go;
    t_time        eff_now;
    logic [POS_W:0] pos;
    logic         run_ok;
    logic         run_better;
    t_slack       slack;
    t_slack       rel_slack;
    t_slack       slice_end;
    logic         rel_better;
    logic         cut;
    t_slice       cut_slice;
    t_slice       due_limit;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_comb begin
        eff_now = r_in_decision ? r_latched_now : r_s1_now;
        pos = r_run_seen ? ({1'b0, r_run_count} + (POS_W+1)'(1)) : '0;

        slack = $signed({2'b00, r_s1_due}) - $signed({2'b00, eff_now})
              - $signed({17'b0, r_s1_rem});
        rel_slack = $signed({2'b00, r_s1_due}) - $signed({2'b00, r_s1_rel})
                  - $signed({17'b0, r_s1_rem});
        slice_end = $signed({2'b00, eff_now}) + $signed({r_slice_acc[SLICE_W-1], r_slice_acc});
        cut_slice = $signed({1'b0, r_s1_rel}) - $signed({1'b0, eff_now});

        run_ok = (r_s1_action == ACT_RUN) && !r_release_seen && (pos < MaxPos);
        run_better = !r_run_seen || (slack < r_best_slack)
                   || ((slack == r_best_slack) && (r_s1_id <= r_best_id));
        rel_better = !r_release_seen || (r_s1_rel < r_earliest)
                   || ((r_s1_rel == r_earliest) && (r_s1_id <= r_earliest_id));
        cut = r_run_seen && ($signed({2'b00, r_s1_rel}) < slice_end)
            && ((rel_slack < r_best_slack)
                || ((rel_slack == r_best_slack) && (r_s1_id <= r_best_id)));

        n_latched_now   = eff_now;
        n_in_decision   = 1'b1;
        n_run_seen      = r_run_seen;
        n_release_seen  = r_release_seen;
        n_run_count     = r_run_count;
        n_best_slack    = r_best_slack;
        n_best_id       = r_best_id;
        n_best_position = r_best_position;
        n_best_due      = r_best_due;
        n_slice_acc     = r_slice_acc;
        n_earliest      = r_earliest;
        n_earliest_id   = r_earliest_id;

        if (r_s1_action == ACT_RUN) begin
            if (run_ok) begin
                n_run_seen  = 1'b1;
                n_run_count = pos[POS_W-1:0];
                if (run_better) begin
                    n_best_slack    = slack;
                    n_best_id       = r_s1_id;
                    n_best_position = pos[POS_W-1:0];
                    n_best_due      = r_s1_due;
                    n_slice_acc     = $signed({16'b0, r_s1_rem});
                end
            end
        end else begin
            n_release_seen = 1'b1;
            if (rel_better) begin
                n_earliest    = r_s1_rel;
                n_earliest_id = r_s1_id;
            end
            if (cut) begin
                n_slice_acc = cut_slice;
            end
        end

        due_limit = $signed({1'b0, n_best_due}) - $signed({1'b0, eff_now});
        if (n_run_seen) begin
            n_out_idle     = 1'b0;
            n_out_id       = n_best_id;
            n_out_position = n_best_position;
            n_out_slice    = (n_slice_acc > due_limit) ? due_limit : n_slice_acc;
        end else begin
            n_out_idle     = 1'b1;
            n_out_id       = '0;
            n_out_position = '0;
            n_out_slice    = n_release_seen
                           ? ($signed({1'b0, n_earliest}) - $signed({1'b0, eff_now}))
                           : '0;
        end

        // The closing entry ends the decision and leaves the state ready for the next.
        if (r_s1_last) begin
            n_in_decision  = 1'b0;
            n_run_seen     = 1'b0;
            n_release_seen = 1'b0;
            n_run_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_action <= i_action;
            r_s1_id     <= i_thread_id;
            r_s1_rem    <= i_remaining_time;
            r_s1_due    <= i_due_time;
            r_s1_rel    <= i_release_at;
            r_s1_now    <= i_now_time;
            r_s1_last   <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_decision  <= 1'b0;
            r_run_seen     <= 1'b0;
            r_release_seen <= 1'b0;
            r_run_count    <= '0;
        end else if (s1_go) begin
            r_in_decision  <= n_in_decision;
            r_run_seen     <= n_run_seen;
            r_release_seen <= n_release_seen;
            r_run_count    <= n_run_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_latched_now   <= n_latched_now;
            r_best_slack    <= n_best_slack;
            r_best_id       <= n_best_id;
            r_best_position <= n_best_position;
            r_best_due      <= n_best_due;
            r_slice_acc     <= n_slice_acc;
            r_earliest      <= n_earliest;
            r_earliest_id   <= n_earliest_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_idle     <= n_out_idle;
            r_out_id       <= n_out_id;
            r_out_position <= n_out_position;
            r_out_slice    <= n_out_slice;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_idle            = r_out_idle;
    assign o_winner_id       = r_out_id;
    assign o_winner_position = r_out_position;
    assign o_slice_ticks     = r_out_slice;

endmodule

`default_nettype wire

// ===== rtl/lsts_checker.sv =====
`default_nettype none

`include "least_slack_time_scheduler_top_assert.svh"

module lsts_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               o_in_ready,
    input  wire               o_out_valid,
    input  wire               i_out_ready,
    input  wire               o_idle,
    input  lsts_pkg::t_id     o_winner_id,
    input  lsts_pkg::t_pos    o_winner_position,
    input  lsts_pkg::t_slice  o_slice_ticks
);
    import lsts_pkg::*;

    // A stalled result keeps its valid and its fields.
    `LSTS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_idle) && $stable(o_winner_id) && $stable(o_winner_position) && $stable(o_slice_ticks))

    // An idle decision names no winner.
    `LSTS_ASSERT_IMPL(a_idle_no_winner, i_clk, i_rst_n, o_out_valid && o_idle, (o_winner_id == t_id'(0)) && (o_winner_position == t_pos'(0)))

    // With the result register free, the input side always takes a transfer.
    `LSTS_ASSERT_IMPL(a_ready_when_free, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready)

    // Reset leaves no result pending and the input side open.
    `LSTS_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind least_slack_time_scheduler_top lsts_checker u_lsts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_idle            (o_idle),
    .o_winner_id       (o_winner_id),
    .o_winner_position (o_winner_position),
    .o_slice_ticks     (o_slice_ticks)
);

`default_nettype wire
